/* rtl/core/pvrp_pkg.sv */
// shared types and constants for the vocabulary record parser
package pvrp_pkg;

	// parse phases
	localparam logic [3:0] PH_OUT_TAG       = 4'd0;
	localparam logic [3:0] PH_OUT_LEN       = 4'd1;
	localparam logic [3:0] PH_OUT_SKIPVAR   = 4'd2;
	localparam logic [3:0] PH_OUT_SKIPLEN   = 4'd3;
	localparam logic [3:0] PH_OUT_SKIPBYTES = 4'd4;
	localparam logic [3:0] PH_SUB_TAG       = 4'd5;
	localparam logic [3:0] PH_SUB_STRLEN    = 4'd6;
	localparam logic [3:0] PH_SUB_STR       = 4'd7;
	localparam logic [3:0] PH_SUB_SCORE     = 4'd8;
	localparam logic [3:0] PH_SUB_SKIPVAR   = 4'd9;
	localparam logic [3:0] PH_SUB_SKIPLEN   = 4'd10;
	localparam logic [3:0] PH_SUB_SKIPBYTES = 4'd11;
	localparam logic [3:0] PH_SUB_DRAIN     = 4'd12;

	// wire types
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_I32    = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_CHUNK   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	// parse state plus the snapshot of a record that is due out
	typedef struct packed {
		logic [3:0]  phase;
		logic [63:0] vv;
		logic [6:0]  vs;
		logic [63:0] sr;
		logic [6:0]  pbh;
		logic [31:0] sc;
		logic [23:0] rc;
		logic        stp;
		logic [32:0] me;
		logic        rec;
		logic [23:0] r_idx;
		logic [6:0]  r_len;
		logic [31:0] r_sc;
	} ps_t;

endpackage

/* rtl/core/pvrp_ram.sv */
// generic single write port ram with registered read
module pvrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/protobuf_vocab_record_parser.sv */
// top level of the vocabulary record parser
//
// channel   direction  handshake               payload
// input     in         in_valid / in_stall     data_byte
// output    out        out_valid / out_stall   kind, record_index, piece_length,
//                                              score_bits, piece_chunk, last
// config    in         cfg_valid / cfg_ready   file_size
//
// a byte is parsed in the cycle it is taken; a byte that closes a record then
// holds the input while a header goes out, then per 8-byte chunk eight reads
// of the piece ram, a wait for the last read data and a load of the output,
// then a summary if the file ends, plus output stalls.
// reset puts the parser at the start of a file with file_size 1.
// the piece ram has no reset; only entries written for the current record are read.
module protobuf_vocab_record_parser #(
	parameter int PIECE_MAX_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [23:0] record_index,
	output logic [6:0]  piece_length,
	output logic [31:0] score_bits,
	output logic [63:0] piece_chunk,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] file_size
);
	import pvrp_pkg::*;

	localparam int RAM_AW = $clog2(PIECE_MAX_BYTES);
	localparam int LIM = (PIECE_MAX_BYTES < 128) ? PIECE_MAX_BYTES : 128;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;

	function automatic ps_t f_feed(ps_t p, logic [7:0] b);
		if (p.vs < 7'd64) begin
			p.vv = p.vv | ({57'd0, b[6:0]} << p.vs[5:0]);
		end
		if (b[7]) begin
			p.vs = (p.vs > 7'd63) ? 7'd70 : p.vs + 7'd7;
		end
		return p;
	endfunction

	function automatic ps_t f_skip_or(ps_t p, logic [63:0] n, logic [3:0] skp,
		logic [3:0] dn);
		p.sr = n;
		p.phase = (n == 64'd0) ? dn : skp;
		return p;
	endfunction

	function automatic ps_t f_emit(ps_t p);
		p.rec = 1'b1;
		p.r_idx = p.rc;
		p.r_len = p.pbh;
		p.r_sc = p.sc;
		if (p.rc != COUNT_MAX) begin
			p.rc = p.rc + 24'd1;
		end
		return p;
	endfunction

	function automatic ps_t f_outer_tag(ps_t p, logic [63:0] tag);
		if (tag[63:3] == 61'd1 && tag[2:0] == WT_LEN) begin
			p.phase = PH_OUT_LEN;
		end else if (tag[2:0] == WT_VARINT) begin
			p.phase = PH_OUT_SKIPVAR;
		end else if (tag[2:0] == WT_LEN) begin
			p.phase = PH_OUT_SKIPLEN;
		end else if (tag[2:0] == WT_I32) begin
			p = f_skip_or(p, 64'd4, PH_OUT_SKIPBYTES, PH_OUT_TAG);
		end else if (tag[2:0] == WT_I64) begin
			p = f_skip_or(p, 64'd8, PH_OUT_SKIPBYTES, PH_OUT_TAG);
		end else begin
			p.stp = 1'b1;
		end
		return p;
	endfunction

	function automatic ps_t f_sub_tag(ps_t p, logic [63:0] tag, logic [63:0] rem);
		if (tag[63:3] == 61'd1 && tag[2:0] == WT_LEN) begin
			p.phase = PH_SUB_STRLEN;
		end else if (tag[63:3] == 61'd2 && tag[2:0] == WT_I32) begin
			if (rem >= 64'd4) begin
				p.sr = 64'd4;
				p.vv = 64'd0;
				p.phase = PH_SUB_SCORE;
			end else begin
				p.phase = PH_SUB_TAG;
			end
		end else if (tag[2:0] == WT_VARINT) begin
			p.phase = PH_SUB_SKIPVAR;
		end else if (tag[2:0] == WT_LEN) begin
			p.phase = PH_SUB_SKIPLEN;
		end else if (tag[2:0] == WT_I32) begin
			p = f_skip_or(p, 64'd4, PH_SUB_SKIPBYTES, PH_SUB_TAG);
		end else if (tag[2:0] == WT_I64) begin
			p = f_skip_or(p, 64'd8, PH_SUB_SKIPBYTES, PH_SUB_TAG);
		end else begin
			p.phase = PH_SUB_DRAIN;
		end
		return p;
	endfunction

	// close the open submessage, using a cut-off varint as read so far
	function automatic ps_t f_finish(ps_t p);
		logic [63:0] t;
		if (p.phase == PH_SUB_TAG && p.vs != 7'd0) begin
			t = p.vv;
			p.vv = 64'd0;
			p.vs = 7'd0;
			p = f_sub_tag(p, t, 64'd0);
		end
		if (p.phase == PH_SUB_STRLEN) begin
			if (p.vv == 64'd0) begin
				p.pbh = 7'd0;
			end
		end
		p = f_emit(p);
		p.phase = PH_OUT_TAG;
		p.vv = 64'd0;
		p.vs = 7'd0;
		p.sr = 64'd0;
		return p;
	endfunction

	logic [31:0] ms_q;
	logic [31:0] bp_q;
	ps_t         ps_q;
	logic [2:0]  st_q;
	logic        em_sum_q;
	logic [23:0] em_cnt_q;
	logic [23:0] em_idx_q;
	logic [6:0]  em_len_q;
	logic [31:0] em_sc_q;
	logic [7:0]  bi_q;
	logic [63:0] chunk_q;
	logic        rd_v_s1;
	logic        rd_use_s1;
	logic [2:0]  rd_slot_s1;

	ps_t              p;
	logic [32:0]      pos;
	logic [32:0]      rem;
	logic             eof;
	logic             ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [RAM_AW-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic             sum;
	logic [23:0]      sum_cnt;
	logic             in_acc;
	logic             out_free;
	logic             out_load;

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free && (st_q == ST_HDR || st_q == ST_PUSH || st_q == ST_SUM);
	assign ram_raddr = bi_q[RAM_AW-1:0];

	always_comb begin
		logic [63:0] v;
		logic [63:0] rem64;
		logic [32:0] rem2;
		logic [6:0]  idx;
		logic [1:0]  sh;
		p = ps_q;
		p.rec = 1'b0;
		p.r_idx = '0;
		p.r_len = '0;
		p.r_sc = '0;
		pos = {1'b0, bp_q} + 33'd1;
		rem = (ps_q.me > pos) ? ps_q.me - pos : 33'd0;
		rem64 = {31'd0, rem};
		rem2 = ({1'b0, ms_q} > pos) ? {1'b0, ms_q} - pos : 33'd0;
		v = '0;
		idx = '0;
		sh = '0;
		ram_we = 1'b0;
		ram_waddr = '0;
		sum = 1'b0;
		sum_cnt = '0;
		eof = (pos >= {1'b0, ms_q});
		if (!ps_q.stp) begin
			case (ps_q.phase)
				PH_OUT_TAG: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						p = f_outer_tag(p, v);
					end
				end
				PH_OUT_LEN: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						if (v > {31'd0, rem2}) begin
							p.stp = 1'b1;
						end else begin
							p.pbh = 7'd0;
							p.sc = 32'd0;
							if (v == 64'd0) begin
								p = f_emit(p);
								p.phase = PH_OUT_TAG;
							end else begin
								p.me = pos + v[32:0];
								p.phase = PH_SUB_TAG;
							end
						end
					end
				end
				PH_OUT_SKIPVAR, PH_SUB_SKIPVAR: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						p.vv = '0;
						p.vs = '0;
						p.phase = (ps_q.phase == PH_OUT_SKIPVAR) ? PH_OUT_TAG : PH_SUB_TAG;
					end
				end
				PH_OUT_SKIPLEN: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						p = f_skip_or(p, v, PH_OUT_SKIPBYTES, PH_OUT_TAG);
					end
				end
				PH_OUT_SKIPBYTES, PH_SUB_SKIPBYTES: begin
					if (p.sr != 64'd0) begin
						p.sr = p.sr - 64'd1;
					end
					if (p.sr == 64'd0) begin
						p.phase = (ps_q.phase == PH_OUT_SKIPBYTES) ? PH_OUT_TAG : PH_SUB_TAG;
					end
				end
				PH_SUB_TAG: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						p = f_sub_tag(p, v, rem64);
					end
				end
				PH_SUB_STRLEN: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						if (v > rem64) begin
							p.phase = PH_SUB_DRAIN;
						end else if (v < 64'(LIM)) begin
							p.pbh = v[6:0];
							p = f_skip_or(p, v, PH_SUB_STR, PH_SUB_TAG);
						end else begin
							p = f_skip_or(p, v, PH_SUB_SKIPBYTES, PH_SUB_TAG);
						end
					end
				end
				PH_SUB_STR: begin
					if (p.sr != 64'd0 && p.sr <= {57'd0, p.pbh}) begin
						idx = p.pbh - p.sr[6:0];
						ram_we = 1'b1;
						ram_waddr = RAM_AW'(idx);
					end
					if (p.sr != 64'd0) begin
						p.sr = p.sr - 64'd1;
					end
					if (p.sr == 64'd0) begin
						p.phase = PH_SUB_TAG;
					end
				end
				PH_SUB_SCORE: begin
					if (p.sr >= 64'd1 && p.sr <= 64'd4) begin
						sh = 2'(3'd4 - p.sr[2:0]);
						p.vv = p.vv | ({56'd0, data_byte} << {sh, 3'b000});
					end
					if (p.sr != 64'd0) begin
						p.sr = p.sr - 64'd1;
					end
					if (p.sr == 64'd0) begin
						p.sc = p.vv[31:0];
						p.vv = '0;
						p.phase = PH_SUB_TAG;
					end
				end
				PH_SUB_SKIPLEN: begin
					p = f_feed(p, data_byte);
					if (!data_byte[7]) begin
						v = p.vv;
						p.vv = '0;
						p.vs = '0;
						if (v > rem64) begin
							p.phase = PH_SUB_DRAIN;
						end else begin
							p = f_skip_or(p, v, PH_SUB_SKIPBYTES, PH_SUB_TAG);
						end
					end
				end
				default: begin
				end
			endcase
			if (p.phase >= PH_SUB_TAG && pos >= p.me) begin
				p = f_finish(p);
			end
		end
		if (eof) begin
			if (!p.stp) begin
				if (p.phase == PH_OUT_TAG && p.vs != 7'd0) begin
					v = p.vv;
					p.vv = '0;
					p.vs = '0;
					p = f_outer_tag(p, v);
				end
				if (!p.stp && p.phase == PH_OUT_LEN) begin
					if (p.vv == 64'd0) begin
						p.pbh = 7'd0;
						p.sc = 32'd0;
						p = f_emit(p);
					end
				end
				if (!p.stp && p.phase >= PH_SUB_TAG) begin
					p = f_finish(p);
				end
			end
			sum = 1'b1;
			sum_cnt = p.rc;
			p.me = '0;
			p.phase = PH_OUT_TAG;
			p.vv = '0;
			p.vs = '0;
			p.sr = '0;
			p.pbh = '0;
			p.sc = '0;
			p.rc = '0;
			p.stp = 1'b0;
		end
	end

	pvrp_ram #(
		.WIDTH(8),
		.DEPTH(PIECE_MAX_BYTES)
	) u_piece_ram (
		.clk   (clk),
		.we    (ram_we && in_acc),
		.waddr (ram_waddr),
		.wdata (data_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			ms_q <= file_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q <= '0;
			ps_q <= '0;
			st_q <= ST_IDLE;
			em_sum_q <= 1'b0;
			bi_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_v_s1 <= (st_q == ST_RD);
			out_valid <= out_load || (out_valid && out_stall);
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						ps_q <= p;
						bp_q <= eof ? 32'd0 : pos[31:0];
						em_sum_q <= sum;
						if (p.rec) begin
							st_q <= ST_HDR;
						end else if (sum) begin
							st_q <= ST_SUM;
						end
					end
				end
				ST_HDR: begin
					if (out_free) begin
						bi_q <= '0;
						if (em_len_q != 7'd0) begin
							st_q <= ST_RD;
						end else if (em_sum_q) begin
							st_q <= ST_SUM;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_RD: begin
					bi_q <= bi_q + 8'd1;
					if (bi_q[2:0] == 3'd7) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					st_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						if (bi_q < {1'b0, em_len_q}) begin
							st_q <= ST_RD;
						end else if (em_sum_q) begin
							st_q <= ST_SUM;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// record snapshot, read pipeline and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			em_cnt_q <= sum_cnt;
			if (p.rec) begin
				em_idx_q <= p.r_idx;
				em_len_q <= p.r_len;
				em_sc_q <= p.r_sc;
			end
		end
		rd_use_s1 <= (bi_q < {1'b0, em_len_q});
		rd_slot_s1 <= bi_q[2:0];
		if (rd_v_s1) begin
			chunk_q[{rd_slot_s1, 3'b000} +: 8] <= rd_use_s1 ? ram_rdata : 8'd0;
		end
		if (out_free) begin
			case (st_q)
				ST_HDR: begin
					kind <= KIND_HEADER;
					record_index <= em_idx_q;
					piece_length <= em_len_q;
					score_bits <= em_sc_q;
					piece_chunk <= '0;
					last <= (em_len_q == 7'd0) && !em_sum_q;
				end
				ST_PUSH: begin
					kind <= KIND_CHUNK;
					record_index <= em_idx_q;
					piece_length <= em_len_q;
					score_bits <= em_sc_q;
					piece_chunk <= chunk_q;
					last <= (bi_q >= {1'b0, em_len_q}) && !em_sum_q;
				end
				ST_SUM: begin
					kind <= KIND_SUMMARY;
					record_index <= em_cnt_q;
					piece_length <= '0;
					score_bits <= '0;
					piece_chunk <= '0;
					last <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end
endmodule
